>>> src/pls_pkg.sv
package pls_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned STAGE_W  = 3;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned DEPTH_W  = 16;
  localparam int unsigned IDX_W    = 4;

  // Shared divider: dividend sized for sample_sum * 1000, divisor for window * 10
  localparam int unsigned DVD_W    = 42;
  localparam int unsigned DVS_W    = 36;
  localparam int unsigned DCNT_W   = 6;

  localparam logic [9:0]  SAMPLE_SCALE = 10'd1000;
  localparam logic [3:0]  LOAD_SCALE   = 4'd10;

  typedef enum logic [OP_W-1:0] {
    OP_STAGE_TIME = 2'd0,
    OP_BLOCK_DONE = 2'd1,
    OP_YIELD      = 2'd2,
    OP_SNAPSHOT   = 2'd3
  } pls_op_e;

  localparam logic [IDX_W-1:0] MET_WINDOW     = 4'd0;
  localparam logic [IDX_W-1:0] MET_BLOCKS     = 4'd1;
  localparam logic [IDX_W-1:0] MET_RATE       = 4'd2;
  localparam logic [IDX_W-1:0] MET_LOAD       = 4'd3;
  localparam logic [IDX_W-1:0] MET_AVG        = 4'd4;
  localparam logic [IDX_W-1:0] MET_PEAK       = 4'd5;
  localparam logic [IDX_W-1:0] MET_HIGH_WATER = 4'd6;
  localparam logic [IDX_W-1:0] MET_BACKLOG    = 4'd7;
  localparam logic [IDX_W-1:0] MET_YIELDS     = 4'd8;
  localparam logic [IDX_W-1:0] MET_STAGE_BASE = 4'd9;

  // Request to the stage-sum memory
  typedef struct packed {
    logic               acc;    // read-modify-write accumulate
    logic               sweep;  // read out and clear
    logic [STAGE_W-1:0] addr;
  } pls_mem_req_t;

endpackage

>>> src/pls_if.sv
interface pls_in_if import pls_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [STAGE_W-1:0]  stage;
  logic [DATA_W-1:0]   stage_time_us;
  logic [DATA_W-1:0]   block_time_us;
  logic [DATA_W-1:0]   sample_count;
  logic [DEPTH_W-1:0]  queue_fill;
  logic [DATA_W-1:0]   span_ms;

  modport source (
    output valid, operation, stage, stage_time_us, block_time_us, sample_count,
           queue_fill, span_ms,
    input  ready
  );
  modport sink (
    input  valid, operation, stage, stage_time_us, block_time_us, sample_count,
           queue_fill, span_ms,
    output ready
  );
endinterface

interface pls_out_if import pls_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  metric_index;
  logic [DATA_W-1:0] metric_value;
  logic              last_metric;

  modport source (
    output valid, metric_index, metric_value, last_metric,
    input  ready
  );
  modport sink (
    input  valid, metric_index, metric_value, last_metric,
    output ready
  );
endinterface

>>> src/pls_div.sv
module pls_div import pls_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DVD_W-1:0]  dividend_i,
  input  logic [DVS_W-1:0]  divisor_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [DATA_W-1:0] quotient_o
);

  localparam logic [DCNT_W-1:0] LastStep = DCNT_W'(DVD_W - 1);

  logic              busy_q, done_q;
  logic [DCNT_W-1:0] cnt_q;
  logic [DVS_W-1:0]  rem_q, dvs_q;
  logic [DVD_W-1:0]  quo_q;
  logic [DVS_W:0]    rem_sh;
  logic [DVS_W+1:0]  trial;
  logic              ge;
  logic [DVS_W-1:0]  rem_d;

  // One quotient bit a cycle, restoring
  always_comb begin
    rem_sh = {rem_q, quo_q[DVD_W-1]};
    trial  = {1'b0, rem_sh} - {2'b00, dvs_q};
    ge     = !trial[DVS_W+1];
    rem_d  = ge ? trial[DVS_W-1:0] : rem_sh[DVS_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastStep) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[DVD_W-2:0], ge};
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q[DATA_W-1:0];

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |-> !busy_q)
    else $error("divider started while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |=> busy_q && cnt_q == '0)
    else $error("divider did not begin after start");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> !busy_q)
    else $error("divider done while still busy");
`endif

endmodule

>>> src/pls_stage_mem.sv
module pls_stage_mem import pls_pkg::*; #(
  parameter int unsigned STAGE_COUNT = 7
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pls_mem_req_t      req_i,
  input  logic [DATA_W-1:0] addend_i,
  output logic [DATA_W-1:0] rdata_o
);

  localparam int unsigned AW = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1;

  logic [DATA_W-1:0] stage_mem [STAGE_COUNT];
  logic [DATA_W-1:0] rdata_q;

  // Entries read as zero until written after reset or after a sweep
  logic [STAGE_COUNT-1:0] vld_q;
  logic                   rd_vld_q;

  logic              s1_valid_q;
  logic [AW-1:0]     s1_addr_q;
  logic [DATA_W-1:0] s1_add_q;

  logic              wb_valid_q;
  logic [AW-1:0]     wb_addr_q;
  logic [DATA_W-1:0] wb_data_q;

  logic [DATA_W-1:0] rdata_m, base, sum;

  // Forward the previous write-back when it hit the same entry
  always_comb begin
    rdata_m = rd_vld_q ? rdata_q : '0;
    base    = (wb_valid_q && wb_addr_q == s1_addr_q) ? wb_data_q : rdata_m;
    sum     = base + s1_add_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      wb_valid_q <= 1'b0;
      vld_q      <= '0;
    end else begin
      s1_valid_q <= req_i.acc;
      wb_valid_q <= s1_valid_q;
      if (s1_valid_q) begin
        vld_q[s1_addr_q] <= 1'b1;
      end else if (req_i.sweep) begin
        vld_q[req_i.addr[AW-1:0]] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.acc || req_i.sweep) begin
      rdata_q  <= stage_mem[req_i.addr[AW-1:0]];
      rd_vld_q <= vld_q[req_i.addr[AW-1:0]];
    end
    if (s1_valid_q) begin
      stage_mem[s1_addr_q] <= sum;
    end else if (req_i.sweep) begin
      stage_mem[req_i.addr[AW-1:0]] <= '0;
    end
    s1_addr_q <= req_i.addr[AW-1:0];
    s1_add_q  <= addend_i;
    wb_addr_q <= s1_addr_q;
    wb_data_q <= sum;
  end

  assign rdata_o = rdata_m;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(req_i.acc && req_i.sweep))
    else $error("accumulate and sweep in the same cycle");
  assert property (@(posedge clk_i) disable iff (!rst_ni) req_i.sweep |-> !s1_valid_q)
    else $error("sweep overlaps a pending write-back");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      s1_valid_q |=> wb_valid_q && wb_data_q == $past(sum))
    else $error("write-back forward register lost");
`endif

endmodule

>>> src/processing_load_statistics.sv
// Processing load statistics monitor.
// Throughput: one stage-time, block-done or yield request per cycle except during a snapshot.
// Latency: block and yield counters update at the accepting edge; a stage sum is
//   written back on the edge after that, with forwarding between back-to-back hits.
// Snapshot: 9 + STAGE_COUNT metrics; rate, load and the averages go through the shared
//   one-bit-a-cycle divider; requests stall until the last metric is loaded for output.
// Reset: asynchronous, active low; all sums, counters and stage sums clear.
module processing_load_statistics import pls_pkg::*; #(
  parameter int unsigned STAGE_COUNT = 7
) (
  input  logic clk_i,
  input  logic rst_ni,
  pls_in_if.sink    req_i,
  pls_out_if.source rsp_o
);

  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(9 + STAGE_COUNT - 1);
  localparam logic [STAGE_W-1:0] StageLimit = STAGE_W'(STAGE_COUNT);

  // Sequencer state codes
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0] state_q, state_d;
  logic [IDX_W-1:0] k_q, k_d;

  // Live statistics
  logic [DATA_W-1:0]  blocks_q, time_sum_q, peak_q, sample_sum_q, backlog_q, yields_q;
  logic [DEPTH_W-1:0] high_water_q;

  // Snapshot working registers
  logic [DATA_W-1:0] window_q;
  logic [DATA_W-1:0] res_q, res_d;

  // Output register
  logic              out_valid_q;
  logic [IDX_W-1:0]  out_idx_q;
  logic [DATA_W-1:0] out_val_q;
  logic              out_last_q;

  logic req_acc, out_load, clear_all;

  // Memory and divider hook-up
  pls_mem_req_t      mem_req;
  logic [DATA_W-1:0] mem_rdata;
  logic [IDX_W-1:0]  stage_idx;
  logic              div_start, div_busy, div_done;
  logic [DVD_W-1:0]  dividend;
  logic [DVS_W-1:0]  divisor;
  logic [DATA_W-1:0] quotient;
  logic [DATA_W-1:0] window_nz;
  logic              no_blocks;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign out_load    = (state_q == S_EMIT) && (!out_valid_q || rsp_o.ready);
  assign clear_all   = out_load && (k_q == LastIdx);

  assign window_nz = (window_q == '0) ? DATA_W'(1) : window_q;
  assign no_blocks = (blocks_q == '0);
  assign stage_idx = k_q - MET_STAGE_BASE;

  // Stage-sum memory: accumulate from requests, read-and-clear from the sweep
  always_comb begin
    mem_req.acc   = req_acc && req_i.operation == OP_STAGE_TIME && req_i.stage < StageLimit;
    mem_req.sweep = (state_q == S_RD);
    mem_req.addr  = mem_req.sweep ? stage_idx[STAGE_W-1:0] : req_i.stage;
  end

  pls_stage_mem #(
    .STAGE_COUNT (STAGE_COUNT)
  ) u_stage_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (mem_req),
    .addend_i (req_i.stage_time_us),
    .rdata_o  (mem_rdata)
  );

  // Pick each metric's value or divider operands. Rate divides samples*1000 by
  // the window; load divides total time by 10*window in one go, which equals
  // dividing by 10 and then by the window.
  always_comb begin
    div_start = 1'b0;
    dividend  = DVD_W'(time_sum_q);
    divisor   = DVS_W'(blocks_q);
    res_d     = res_q;
    case (k_q)
      MET_WINDOW:     res_d = window_q;
      MET_BLOCKS:     res_d = blocks_q;
      MET_RATE: begin
        div_start = 1'b1;
        dividend  = DVD_W'(sample_sum_q) * DVD_W'(SAMPLE_SCALE);
        divisor   = DVS_W'(window_nz);
      end
      MET_LOAD: begin
        div_start = 1'b1;
        divisor   = DVS_W'(window_nz) * DVS_W'(LOAD_SCALE);
      end
      MET_AVG: begin
        div_start = !no_blocks;
        res_d     = '0;
      end
      MET_PEAK:       res_d = peak_q;
      MET_HIGH_WATER: res_d = DATA_W'(high_water_q);
      MET_BACKLOG:    res_d = backlog_q;
      MET_YIELDS:     res_d = yields_q;
      default: begin
        // Stage average, sum just swept out of the memory
        div_start = !no_blocks;
        dividend  = DVD_W'(mem_rdata);
        res_d     = '0;
      end
    endcase
    if (state_q != S_LOAD) begin
      div_start = 1'b0;
      res_d     = div_done ? quotient : res_q;
    end
  end

  pls_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Sequencer: load, optionally divide, emit; stage metrics sweep first
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    case (state_q)
      S_IDLE: begin
        if (req_acc && req_i.operation == OP_SNAPSHOT) begin
          state_d = S_LOAD;
          k_d     = MET_WINDOW;
        end
      end
      S_RD:   state_d = S_LOAD;
      S_LOAD: state_d = div_start ? S_DIV : S_EMIT;
      S_DIV:  if (div_done) state_d = S_EMIT;
      S_EMIT: begin
        if (out_load) begin
          if (k_q == LastIdx) begin
            state_d = S_IDLE;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = (k_q >= MET_YIELDS) ? S_RD : S_LOAD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Statistics: accumulate on requests, clear as the last metric enters the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blocks_q     <= '0;
      time_sum_q   <= '0;
      peak_q       <= '0;
      sample_sum_q <= '0;
      high_water_q <= '0;
      backlog_q    <= '0;
      yields_q     <= '0;
    end else if (clear_all) begin
      blocks_q     <= '0;
      time_sum_q   <= '0;
      peak_q       <= '0;
      sample_sum_q <= '0;
      high_water_q <= '0;
      backlog_q    <= '0;
      yields_q     <= '0;
    end else if (req_acc) begin
      if (req_i.operation == OP_BLOCK_DONE) begin
        blocks_q     <= blocks_q + 1'b1;
        time_sum_q   <= time_sum_q + req_i.block_time_us;
        sample_sum_q <= sample_sum_q + req_i.sample_count;
        if (req_i.block_time_us > peak_q) begin
          peak_q <= req_i.block_time_us;
        end
        if (req_i.queue_fill > high_water_q) begin
          high_water_q <= req_i.queue_fill;
        end
        if (req_i.queue_fill != '0) begin
          backlog_q <= backlog_q + 1'b1;
        end
      end else if (req_i.operation == OP_YIELD) begin
        yields_q <= yields_q + 1'b1;
      end
    end
  end

  // Payload registers: hold the window, the pending value and the output
  always_ff @(posedge clk_i) begin
    if (req_acc && req_i.operation == OP_SNAPSHOT) begin
      window_q <= req_i.span_ms;
    end
    res_q <= res_d;
    if (out_load) begin
      out_idx_q  <= k_q;
      out_val_q  <= res_q;
      out_last_q <= (k_q == LastIdx);
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.metric_index = out_idx_q;
  assign rsp_o.metric_value = out_val_q;
  assign rsp_o.last_metric  = out_last_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      rsp_o.valid && rsp_o.last_metric |-> rsp_o.metric_index == LastIdx)
    else $error("last metric flag on the wrong index");
  assert property (@(posedge clk_i) disable iff (!rst_ni) req_i.ready |-> !div_busy)
    else $error("accepting requests while dividing");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      state_q == S_DIV |-> div_busy || div_done)
    else $error("waiting on an idle divider");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      state_q == S_RD |-> k_q >= MET_STAGE_BASE)
    else $error("memory sweep outside stage metrics");
`endif

endmodule

>>> dv/tb_processing_load_statistics.sv
module tb_processing_load_statistics;
  import pls_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Block configuration and derived metric count
  localparam int unsigned STAGES = 7;
  localparam int unsigned NMET   = 9 + STAGES;

  // Run shape
  localparam int unsigned N_RANDOM     = 355;
  localparam int unsigned HOLD_CYCLES  = 400;
  // Wait after the last owed metric; leave ample room for stray output
  localparam int unsigned DRAIN_CYCLES = 600;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;

  typedef logic [NMET-1:0][DATA_W-1:0] metric_vec_t;

  typedef struct packed {
    pls_op_e              op;
    logic [STAGE_W-1:0]   stage;
    logic [DATA_W-1:0]    stage_time_us;
    logic [DATA_W-1:0]    block_time_us;
    logic [DATA_W-1:0]    sample_count;
    logic [DEPTH_W-1:0]   queue_fill;
    logic [DATA_W-1:0]    span_ms;
  } stats_req_t;

  // One line of stimulus; typed rows carry their snapshot values by hand
  typedef struct packed {
    stats_req_t  req;
    logic        typed;
    metric_vec_t exp_vals;
  } stim_row_t;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] val;
    logic              last;
  } metric_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  pls_in_if  req_if ();
  pls_out_if rsp_if ();

  processing_load_statistics #(
    .STAGE_COUNT (STAGES)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shadow statistics: the testbench's own copy of the accumulators
  // --------------------------------------------------------------------------
  logic [DATA_W-1:0]  stage_sum [STAGES];
  logic [DATA_W-1:0]  block_cnt;
  logic [DATA_W-1:0]  block_time_total;
  logic [DATA_W-1:0]  block_time_max;
  logic [DATA_W-1:0]  sample_total;
  logic [DEPTH_W-1:0] depth_high;
  logic [DATA_W-1:0]  backlog_cnt;
  logic [DATA_W-1:0]  yield_cnt;

  // Metrics still owed by the block, oldest first
  metric_t metric_q [$];

  int  errors = 0;
  bit  idle_on = 1'b1;
  bit  hold_off_go = 1'b0;
  int  cycle_cnt = 0;

  function automatic void clear_stats();
    foreach (stage_sum[k]) stage_sum[k] = '0;
    block_cnt        = '0;
    block_time_total = '0;
    block_time_max   = '0;
    sample_total     = '0;
    depth_high       = '0;
    backlog_cnt      = '0;
    yield_cnt        = '0;
  endfunction

  // Work out the metric set a snapshot reports from the current shadow state.
  // A zero window divides as one; averages with no blocks are zero.
  function automatic metric_vec_t snapshot_metrics(input logic [DATA_W-1:0] win_ms);
    metric_vec_t v;
    logic [63:0] win;
    v   = '0;
    win = (win_ms == '0) ? 64'd1 : {32'd0, win_ms};
    v[MET_WINDOW]     = win_ms;
    v[MET_BLOCKS]     = block_cnt;
    v[MET_RATE]       = 32'(({32'd0, sample_total} * SAMPLE_SCALE) / win);
    v[MET_LOAD]       = 32'(({32'd0, block_time_total} / LOAD_SCALE) / win);
    v[MET_AVG]        = (block_cnt != '0) ? block_time_total / block_cnt : '0;
    v[MET_PEAK]       = block_time_max;
    v[MET_HIGH_WATER] = {16'd0, depth_high};
    v[MET_BACKLOG]    = backlog_cnt;
    v[MET_YIELDS]     = yield_cnt;
    for (int k = 0; k < STAGES; k++) begin
      v[MET_STAGE_BASE + k] = (block_cnt != '0) ? stage_sum[k] / block_cnt : '0;
    end
    return v;
  endfunction

  // Apply one accepted request to the shadow state; a snapshot queues its metrics
  function automatic void account_request(input stim_row_t row);
    metric_vec_t vals;
    case (row.req.op)
      OP_STAGE_TIME: begin
        // Drop stage indexes outside the configured range
        if (row.req.stage < STAGES)
          stage_sum[row.req.stage] = stage_sum[row.req.stage] + row.req.stage_time_us;
      end
      OP_BLOCK_DONE: begin
        block_cnt        = block_cnt + 1;
        block_time_total = block_time_total + row.req.block_time_us;
        sample_total     = sample_total + row.req.sample_count;
        if (row.req.block_time_us > block_time_max) block_time_max = row.req.block_time_us;
        if (row.req.queue_fill > depth_high) depth_high = row.req.queue_fill;
        if (row.req.queue_fill != '0) backlog_cnt = backlog_cnt + 1;
      end
      OP_YIELD: begin
        yield_cnt = yield_cnt + 1;
      end
      default: begin
        vals = row.typed ? row.exp_vals : snapshot_metrics(row.req.span_ms);
        for (int k = 0; k < NMET; k++) begin
          metric_q.push_back('{idx: IDX_W'(k), val: vals[k], last: (k == NMET - 1)});
        end
        clear_stats();
      end
    endcase
  endfunction

  function automatic void check_metric(input logic [IDX_W-1:0] idx,
                                       input logic [DATA_W-1:0] val,
                                       input logic last);
    metric_t want;
    if (metric_q.size() == 0) begin
      $display("%0t: unexpected metric: index %0d value %h last %0b",
               $time, idx, val, last);
      errors++;
      return;
    end
    want = metric_q.pop_front();
    if (idx !== want.idx) begin
      $display("%0t: metric_index expected %0d actual %0d", $time, want.idx, idx);
      errors++;
    end
    if (val !== want.val) begin
      $display("%0t: metric_value (index %0d) expected %h actual %h",
               $time, want.idx, want.val, val);
      errors++;
    end
    if (last !== want.last) begin
      $display("%0t: last_metric (index %0d) expected %0b actual %0b",
               $time, want.idx, want.last, last);
      errors++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic stim_row_t mk_row(input pls_op_e op, input logic [STAGE_W-1:0] stage,
                                       input logic [DATA_W-1:0] st_us,
                                       input logic [DATA_W-1:0] blk_us,
                                       input logic [DATA_W-1:0] samples,
                                       input logic [DEPTH_W-1:0] depth,
                                       input logic [DATA_W-1:0] win);
    stim_row_t row;
    row.req.op            = op;
    row.req.stage         = stage;
    row.req.stage_time_us = st_us;
    row.req.block_time_us = blk_us;
    row.req.sample_count  = samples;
    row.req.queue_fill    = depth;
    row.req.span_ms       = win;
    row.typed             = 1'b0;
    row.exp_vals          = '0;
    return row;
  endfunction

  // Favour the corners: tiny values, all-ones and just below it
  function automatic logic [DATA_W-1:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return DATA_W'($urandom_range(0, 15));
      1:       return '1;
      2:       return 32'hFFFF_FFFF - DATA_W'($urandom_range(0, 255));
      3:       return DATA_W'($urandom_range(0, 100000));
      default: return DATA_W'($urandom);
    endcase
  endfunction

  function automatic stim_row_t rand_row(input bit force_snap);
    stim_row_t row;
    int pick;
    pick = $urandom_range(0, 99);
    row  = mk_row(OP_YIELD, STAGE_W'($urandom_range(0, 7)), rand_word(), rand_word(),
                  rand_word(), DEPTH_W'($urandom), rand_word());
    if (force_snap || pick >= 90) row.req.op = OP_SNAPSHOT;
    else if (pick < 45)          row.req.op = OP_STAGE_TIME;
    else if (pick < 80)          row.req.op = OP_BLOCK_DONE;
    case ($urandom_range(0, 3))
      0:       row.req.queue_fill = '0;
      1:       row.req.queue_fill = '1;
      default: ;
    endcase
    case ($urandom_range(0, 5))
      0:       row.req.span_ms = '0;
      1:       row.req.span_ms = DATA_W'($urandom_range(1, 2000));
      2:       row.req.span_ms = '1;
      default: ;
    endcase
    return row;
  endfunction

  // Offer one request from the falling edge and hold it until accepted.
  // Insert an idle burst first now and then, while idling is on.
  task automatic issue_request(input stim_row_t row);
    int gap;
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 7);
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid         <= 1'b1;
    req_if.operation     <= row.req.op;
    req_if.stage         <= row.req.stage;
    req_if.stage_time_us <= row.req.stage_time_us;
    req_if.block_time_us <= row.req.block_time_us;
    req_if.sample_count  <= row.req.sample_count;
    req_if.queue_fill    <= row.req.queue_fill;
    req_if.span_ms       <= row.req.span_ms;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    account_request(row);
  endtask

  // --------------------------------------------------------------------------
  // Result side: ready in bursts, plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : sink_ctrl
    int n;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_go) begin
        // Hold ready low long enough for the block to back up into its input
        hold_off_go = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 7);
        rsp_if.ready <= 1'b0;
        repeat (n - 1) @(negedge clk_i);
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Sample results at the rising edge and compare against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
      check_metric(rsp_if.metric_index, rsp_if.metric_value, rsp_if.last_metric);
  end

  // Watchdog: stop a hung run
  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("tb_processing_load_statistics: done, errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    stim_row_t   dir_tab [$];
    stim_row_t   row;
    metric_vec_t v;

    rst_ni               = 1'b0;
    req_if.valid         = 1'b0;
    req_if.operation     = OP_STAGE_TIME;
    req_if.stage         = '0;
    req_if.stage_time_us = '0;
    req_if.block_time_us = '0;
    req_if.sample_count  = '0;
    req_if.queue_fill    = '0;
    req_if.span_ms       = '0;
    clear_stats();

    // Directed table. Snapshot rows straight after reset or a clear, and the
    // all-extremes snapshot, carry their values by hand.

    // Fresh out of reset with a zero window: everything reads zero
    row = mk_row(OP_SNAPSHOT, '0, '0, '0, '0, '0, '0);
    row.typed = 1'b1;
    dir_tab.push_back(row);

    // Widest window, still nothing accumulated
    row = mk_row(OP_SNAPSHOT, '1, '1, '1, '1, '1, '1);
    row.typed = 1'b1;
    row.exp_vals[MET_WINDOW] = '1;
    dir_tab.push_back(row);

    // All-ones block, stage extremes, an ignored stage, one yield
    dir_tab.push_back(mk_row(OP_BLOCK_DONE, '0, '0, '1, '1, '1, '0));
    dir_tab.push_back(mk_row(OP_STAGE_TIME, 3'd0, '1, '0, '0, '0, '0));
    dir_tab.push_back(mk_row(OP_STAGE_TIME, 3'd6, 32'd1, '0, '0, '0, '0));
    dir_tab.push_back(mk_row(OP_STAGE_TIME, 3'd7, 32'hDEAD_BEEF, '0, '0, '0, '0));
    dir_tab.push_back(mk_row(OP_YIELD, '0, '0, '0, '0, '0, '0));
    v = '0;
    v[MET_WINDOW]         = 32'd1;
    v[MET_BLOCKS]         = 32'd1;
    v[MET_RATE]           = 32'hFFFF_FC18;  // (2^32-1)*1000 wrapped
    v[MET_LOAD]           = 32'h1999_9999;  // (2^32-1)/10
    v[MET_AVG]            = '1;
    v[MET_PEAK]           = '1;
    v[MET_HIGH_WATER]     = 32'h0000_FFFF;
    v[MET_BACKLOG]        = 32'd1;
    v[MET_YIELDS]         = 32'd1;
    v[MET_STAGE_BASE]     = '1;
    v[MET_STAGE_BASE + 6] = 32'd1;
    row = mk_row(OP_SNAPSHOT, '0, '0, '0, '0, '0, 32'd1);
    row.typed    = 1'b1;
    row.exp_vals = v;
    dir_tab.push_back(row);

    // Sums that wrap, zero and non-zero depth, then a zero window with blocks
    dir_tab.push_back(mk_row(OP_BLOCK_DONE, '0, '0, '1, 32'h8000_0000, '0, '0));
    dir_tab.push_back(mk_row(OP_BLOCK_DONE, '0, '0, 32'd2, 32'h8000_0001, 16'd1, '0));
    dir_tab.push_back(mk_row(OP_BLOCK_DONE, '0, '0, '0, '0, 16'h8000, '0));
    dir_tab.push_back(mk_row(OP_STAGE_TIME, 3'd1, '1, '0, '0, '0, '0));
    dir_tab.push_back(mk_row(OP_STAGE_TIME, 3'd1, '1, '0, '0, '0, '0));
    dir_tab.push_back(mk_row(OP_STAGE_TIME, 3'd5, '0, '0, '0, '0, '0));
    dir_tab.push_back(mk_row(OP_YIELD, '0, '0, '0, '0, '0, '0));
    dir_tab.push_back(mk_row(OP_YIELD, '0, '0, '0, '0, '0, '0));
    dir_tab.push_back(mk_row(OP_SNAPSHOT, '0, '0, '0, '0, '0, '0));

    // Stage time but no blocks: averages stay zero
    dir_tab.push_back(mk_row(OP_STAGE_TIME, 3'd3, 32'd12345, '0, '0, '0, '0));
    dir_tab.push_back(mk_row(OP_YIELD, '0, '0, '0, '0, '0, '0));
    row = mk_row(OP_SNAPSHOT, '0, '0, '0, '0, '0, 32'd7);
    row.typed = 1'b1;
    row.exp_vals[MET_WINDOW] = 32'd7;
    row.exp_vals[MET_YIELDS] = 32'd1;
    dir_tab.push_back(row);

    // Hits on one stage sum, back to back when no idle burst comes between
    dir_tab.push_back(mk_row(OP_STAGE_TIME, 3'd2, 32'd1, '0, '0, '0, '0));
    dir_tab.push_back(mk_row(OP_STAGE_TIME, 3'd2, 32'd1, '0, '0, '0, '0));
    dir_tab.push_back(mk_row(OP_STAGE_TIME, 3'd2, 32'd1, '0, '0, '0, '0));
    dir_tab.push_back(mk_row(OP_STAGE_TIME, 3'd2, '1, '0, '0, '0, '0));
    dir_tab.push_back(mk_row(OP_BLOCK_DONE, '0, '0, 32'd100, 32'd1000, 16'd2, '0));
    dir_tab.push_back(mk_row(OP_SNAPSHOT, '0, '0, '0, '0, '0, 32'd3));

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_tab[k]) issue_request(dir_tab[k]);

    // Random part. Start with the long hold-off and force early snapshots so
    // the output backs up; turn idle bursts off in the middle and at the end.
    hold_off_go = 1'b1;
    for (int i = 0; i < N_RANDOM; i++) begin
      idle_on = !((i >= 150 && i < 200) || i >= N_RANDOM - 60);
      issue_request(rand_row(i == 2 || i == 5));
    end
    @(negedge clk_i);
    req_if.valid <= 1'b0;

    // Drain: wait for every owed metric, then a little longer for strays
    while (metric_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (errors == 0) begin
      $display("tb_processing_load_statistics: done, clean");
    end else begin
      $display("tb_processing_load_statistics: done, errors");
    end
    $finish;
  end

endmodule
